// ----- hdl/uist_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_pkg
// Shared types and constants for the unique id schedule table.
// ----------------------------------------------------------------------------
package uist_pkg;

    localparam int ID_W              = 32;
    localparam int IN_PAYLOAD_W      = 32;
    localparam int DEF_TABLE_DEPTH   = 16;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    typedef enum logic [1:0] {
        STAT_STORED = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef enum logic {
        MODE_AUTO   = 1'b0,
        MODE_MANUAL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                   mode;
        logic [ID_W-1:0]         requested_id;
        logic [IN_PAYLOAD_W-1:0] payload;
    } t_in_beat;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] assigned_id;
    } t_out_beat;

endpackage

// ----- hdl/uist_entry_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_entry_store
// Entry memories: an id memory with one registered read port and a payload
// memory that is only written.
// ----------------------------------------------------------------------------
module uist_entry_store #(
    parameter int TABLE_DEPTH   = uist_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WIDTH = uist_pkg::DEF_PAYLOAD_WIDTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [uist_pkg::ID_W-1:0] i_wr_id,
    input  logic [PAYLOAD_WIDTH-1:0] i_wr_payload,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [uist_pkg::ID_W-1:0] o_rd_id
);

    logic [uist_pkg::ID_W-1:0] mem_id  [TABLE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0]  mem_pay [TABLE_DEPTH];
    logic [uist_pkg::ID_W-1:0] r_rd_id;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_id[i_wr_addr]  <= i_wr_id;
            mem_pay[i_wr_addr] <= i_wr_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_id <= mem_id[i_rd_addr];
        end
    end

    assign o_rd_id = r_rd_id;

endmodule

// ----- hdl/uist_sched_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_sched_ctrl
// Request sequencer: picks the candidate id, scans the id memory one entry
// per cycle, restarts on an automatic-id collision and appends the entry unless it is rejected or the table is full.
// ----------------------------------------------------------------------------
module uist_sched_ctrl #(
    parameter int TABLE_DEPTH   = uist_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WIDTH = uist_pkg::DEF_PAYLOAD_WIDTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  uist_pkg::t_in_beat        i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output uist_pkg::t_out_beat       o_data,
    input  logic [uist_pkg::ID_W-1:0] i_reserved_id,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [uist_pkg::ID_W-1:0] o_wr_id,
    output logic [PAYLOAD_WIDTH-1:0]  o_wr_payload,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  logic [uist_pkg::ID_W-1:0] i_rd_id
);

    uist_pkg::t_state                     r_state, n_state;
    uist_pkg::t_mode                      r_mode, n_mode;
    logic [uist_pkg::ID_W-1:0]            r_cand, n_cand;
    logic [uist_pkg::ID_W-1:0]            r_auto_id, n_auto_id;
    logic [uist_pkg::IN_PAYLOAD_W-1:0]    r_payload, n_payload;
    logic [CW-1:0]                        r_addr, n_addr;
    logic [CW-1:0]                        r_count, n_count;
    logic                                 r_pend, n_pend;
    logic                                 r_reject, n_reject;
    logic                                 r_out_vld, n_out_vld;
    uist_pkg::t_out_beat                  r_out, n_out;

    logic                                 accept;
    logic                                 hit;
    logic                                 scan_end;
    logic                                 out_free;
    logic                                 full;
    uist_pkg::t_status                    fin_status;

    assign accept   = i_valid && (r_state == uist_pkg::ST_IDLE);
    assign hit      = r_pend && (i_rd_id == r_cand);
    assign scan_end = (r_addr == r_count) && !r_pend;
    assign out_free = !r_out_vld || !i_stall;
    assign full     = (r_count == CW'(TABLE_DEPTH));

    always_comb begin
        if (r_reject || (r_cand == i_reserved_id)) begin
            fin_status = uist_pkg::STAT_REJECT;
        end else if (full) begin
            fin_status = uist_pkg::STAT_FULL;
        end else begin
            fin_status = uist_pkg::STAT_STORED;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uist_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = uist_pkg::ST_SCAN;
                end
            end
            uist_pkg::ST_SCAN: begin
                priority if (hit && (r_mode == uist_pkg::MODE_MANUAL)) begin
                    n_state = uist_pkg::ST_FINISH;
                end else if (hit) begin
                    n_state = uist_pkg::ST_SCAN;
                end else if (scan_end) begin
                    n_state = uist_pkg::ST_FINISH;
                end else begin
                    n_state = uist_pkg::ST_SCAN;
                end
            end
            uist_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = uist_pkg::ST_IDLE;
                end
            end
            default: n_state = uist_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_mode       = r_mode;
        n_cand       = r_cand;
        n_auto_id    = r_auto_id;
        n_payload    = r_payload;
        n_addr       = r_addr;
        n_count      = r_count;
        n_pend       = 1'b0;
        n_reject     = r_reject;
        n_out_vld    = r_out_vld && i_stall;
        n_out        = r_out;
        o_rd_en      = 1'b0;
        o_wr_en      = 1'b0;
        unique case (r_state)
            uist_pkg::ST_IDLE: begin
                if (accept) begin
                    n_mode    = i_data.mode;
                    n_payload = i_data.payload;
                    n_addr    = '0;
                    n_reject  = 1'b0;
                    if (i_data.mode == uist_pkg::MODE_AUTO) begin
                        n_auto_id = r_auto_id + uist_pkg::ID_W'(1);
                        n_cand    = r_auto_id + uist_pkg::ID_W'(1);
                    end else begin
                        n_cand = i_data.requested_id;
                    end
                end
            end
            uist_pkg::ST_SCAN: begin
                if (hit) begin
                    if (r_mode == uist_pkg::MODE_MANUAL) begin
                        n_reject = 1'b1;
                    end else begin
                        // Collision on an automatic id: step and rescan.
                        n_cand = r_cand + uist_pkg::ID_W'(1);
                        n_addr = '0;
                    end
                end else if (r_addr != r_count) begin
                    o_rd_en = 1'b1;
                    n_addr  = r_addr + CW'(1);
                    n_pend  = 1'b1;
                end
            end
            uist_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.status      = fin_status;
                    n_out.assigned_id = (fin_status == uist_pkg::STAT_STORED) ?
                                        r_cand : i_reserved_id;
                    if (fin_status == uist_pkg::STAT_STORED) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rd_addr    = r_addr[AW-1:0];
    assign o_wr_addr    = r_count[AW-1:0];
    assign o_wr_id      = r_cand;
    assign o_wr_payload = PAYLOAD_WIDTH'(r_payload);
    assign o_stall      = (r_state != uist_pkg::ST_IDLE);
    assign o_valid      = r_out_vld;
    assign o_data       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= uist_pkg::ST_IDLE;
            r_auto_id    <= '0;
            r_count      <= '0;
            r_pend       <= 1'b0;
            r_reject     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_addr       <= '0;
            r_mode       <= uist_pkg::MODE_AUTO;
        end else begin
            r_state      <= n_state;
            r_auto_id    <= n_auto_id;
            r_count      <= n_count;
            r_pend       <= n_pend;
            r_reject     <= n_reject;
            r_out_vld    <= n_out_vld;
            r_addr       <= n_addr;
            r_mode       <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand    <= n_cand;
        r_payload <= n_payload;
        r_out     <= n_out;
    end

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // An accepted request starts a fresh scan from the first entry.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == uist_pkg::ST_SCAN) && (r_addr == '0) && !r_pend)
        else $error("scan did not start from entry zero");

    // An automatic-id collision steps the candidate by one.
    a_auto_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uist_pkg::ST_SCAN && hit && r_mode == uist_pkg::MODE_AUTO)
        |=> (r_cand == $past(r_cand) + uist_pkg::ID_W'(1)))
        else $error("automatic id did not advance after collision");

    // Every append grows the table by exactly one entry.
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not advance the entry count");

endmodule

// ----- hdl/unique_id_schedule_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_id_schedule_table
// Append-only table of scheduled entries keyed by unique 32-bit ids.
// ----------------------------------------------------------------------------
// Usage: a request beat on i_valid/o_stall carries a mode bit, a requested id
// and a payload word. In automatic mode the internal id counter advances by
// one and becomes the candidate; each time the candidate matches a stored id
// it is incremented and the table is scanned again from the first entry. In
// manual mode the requested id is the candidate and any match rejects it.
// A candidate equal to the reserved id is rejected (status 1); a full table
// gives status 2; otherwise the entry is appended and status 0 returns the id.
// Failed requests answer with the reserved id. One result beat per request
// leaves on o_valid/i_stall.
// Timing: the id memory is read one entry per cycle through its registered
// read port, and each automatic-id collision restarts the scan. One request
// is in work at a time; o_stall is high meanwhile, and the next request can
// be accepted in the cycle after the result register is loaded. A stalled
// receiver only holds the sequencer when a new result is ready and the old
// one is still unread.
// Reset empties the table, clears the id counter and sets the reserved id to
// zero. The reserved id is written through i_cfg_we/i_cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module unique_id_schedule_table #(
    parameter int TABLE_DEPTH   = uist_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WIDTH = uist_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  uist_pkg::t_in_beat        i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output uist_pkg::t_out_beat       o_data,
    input  logic                      i_cfg_we,
    input  logic [uist_pkg::ID_W-1:0] i_cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [uist_pkg::ID_W-1:0] r_reserved_id;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [uist_pkg::ID_W-1:0] wr_id;
    logic [PAYLOAD_WIDTH-1:0]  wr_payload;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [uist_pkg::ID_W-1:0] rd_id;

    // Reserved id register, the only configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved_id <= '0;
        end else if (i_cfg_we) begin
            r_reserved_id <= i_cfg_wdata;
        end
    end

    uist_sched_ctrl #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data),
        .i_reserved_id(r_reserved_id),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_id      (wr_id),
        .o_wr_payload (wr_payload),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_id      (rd_id)
    );

    uist_entry_store #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_id     (wr_id),
        .i_wr_payload(wr_payload),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_id     (rd_id)
    );

    // An accepted request makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without going busy");

    // A new result beat only appears after the block was busy with a request.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat without a request in work");

    // The memory is never read and written in the same cycle.
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("simultaneous read and append");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the unique id schedule table.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the id table, the automatic id
// counter and the reserved id. Every request beat that the block accepts is
// booked there, and the answer that the table should give is queued. Every
// answer beat that leaves the block is compared field by field with the
// oldest queued answer.
// The run opens with a directed sequence that walks through rejection of the
// reserved id, duplicates, the automatic skip scan, an automatic id that
// lands on the reserved id, and a full table. Random requests follow in
// phases, each with a new reserved id. The sender works in bursts, and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;

    localparam int              DEPTH           = uist_pkg::DEF_TABLE_DEPTH;
    localparam int              RANDOM_REQUESTS = 600;
    localparam int              CYCLE_LIMIT     = 1000000;
    localparam int              SETTLE_CYCLES   = 300;
    localparam logic [uist_pkg::ID_W-1:0] ID_MAX = '1;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_style;

    // Scoreboard: a mirror of the table that predicts the answer to each
    // accepted request and checks the answers that come back, in order.
    class id_table_model;
        logic [uist_pkg::ID_W-1:0] reserved_id;
        logic [uist_pkg::ID_W-1:0] auto_id;
        int                        entry_count;
        logic [uist_pkg::ID_W-1:0] entry_ids [DEPTH];
        uist_pkg::t_out_beat       pending_answers [$];
        int                        mismatches;

        function new();
            reserved_id = '0;
            auto_id     = '0;
            entry_count = 0;
            mismatches  = 0;
        endfunction

        function bit holds_id(logic [uist_pkg::ID_W-1:0] id);
            for (int i = 0; i < entry_count; i++) begin
                if (entry_ids[i] == id) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(uist_pkg::t_in_beat req);
            logic [uist_pkg::ID_W-1:0] candidate;
            uist_pkg::t_out_beat       answer;
            if (req.mode == uist_pkg::MODE_AUTO) begin
                // The counter moves on every automatic request; the scan then
                // steps over stored ids but not over the reserved one.
                auto_id   = auto_id + 1'b1;
                candidate = auto_id;
                for (int guard = 0; guard <= DEPTH && holds_id(candidate); guard++) begin
                    candidate = candidate + 1'b1;
                end
            end else begin
                candidate = req.requested_id;
            end
            if (candidate == reserved_id || holds_id(candidate)) begin
                answer.status      = uist_pkg::STAT_REJECT;
                answer.assigned_id = reserved_id;
            end else if (entry_count >= DEPTH) begin
                answer.status      = uist_pkg::STAT_FULL;
                answer.assigned_id = reserved_id;
            end else begin
                entry_ids[entry_count] = candidate;
                entry_count++;
                answer.status      = uist_pkg::STAT_STORED;
                answer.assigned_id = candidate;
            end
            pending_answers.push_back(answer);
        endfunction

        function void check_result(uist_pkg::t_out_beat got);
            uist_pkg::t_out_beat want;
            if (pending_answers.size() == 0) begin
                $error("answer with no request pending: status %0d, assigned_id %h",
                       got.status, got.assigned_id);
                mismatches++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.assigned_id !== want.assigned_id) begin
                $error("assigned_id: expected %h, actual %h",
                       want.assigned_id, got.assigned_id);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    uist_pkg::t_in_beat        req_beat  = '0;
    logic                      ans_valid;
    logic                      ans_stall = 1'b0;
    uist_pkg::t_out_beat       ans_beat;
    logic                      cfg_we    = 1'b0;
    logic [uist_pkg::ID_W-1:0] cfg_wdata = '0;

    id_table_model   table_model;
    int              cycle_count = 0;
    t_stall_style    stall_style = STALL_NONE;
    int              stall_left  = 0;

    unique_id_schedule_table u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_stall     (req_stall),
        .i_data      (req_beat),
        .o_valid     (ans_valid),
        .i_stall     (ans_stall),
        .o_data      (ans_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a run that hangs on a handshake ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // The receiver keeps each stall style for a random stretch: no stall at
    // all, occasional stalls, mostly stalled, or a stall that toggles at each
    // falling edge, so that back pressure falls on every phase of a table scan.
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            stall_left  = $urandom_range(20, 120);
        end else begin
            stall_left--;
        end
        case (stall_style)
            STALL_NONE: begin
                ans_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                ans_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                ans_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                ans_stall <= ~ans_stall;
            end
        endcase
    end

    // Answer beats are taken at the rising edge where valid is high and the
    // receiver does not stall.
    always @(posedge clk) begin
        if (rst_n && ans_valid && !ans_stall) begin
            table_model.check_result(ans_beat);
        end
    end

    // Presents one request beat from the falling edge on and holds it until
    // the block takes it. Valid stays high on return, so back-to-back
    // requests keep it high without a gap.
    task automatic send_request(input uist_pkg::t_mode mode,
                                input logic [uist_pkg::ID_W-1:0] id,
                                input logic [uist_pkg::IN_PAYLOAD_W-1:0] word);
        uist_pkg::t_in_beat beat;
        beat.mode         = mode;
        beat.requested_id = id;
        beat.payload      = word;
        @(negedge clk);
        req_valid <= 1'b1;
        req_beat  <= beat;
        do @(posedge clk); while (req_stall);
        table_model.note_request(beat);
    endtask

    task automatic idle_cycles(input int count);
        repeat (count) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    // Stops sending and waits until every queued answer has come back.
    task automatic wait_for_answers();
        @(negedge clk);
        req_valid <= 1'b0;
        while (table_model.pending_answers.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // The reserved id may only change while the table is idle.
    task automatic write_reserved(input logic [uist_pkg::ID_W-1:0] value);
        wait_for_answers();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        table_model.reserved_id = value;
    endtask

    initial begin
        logic [uist_pkg::ID_W-1:0]         want_id;
        logic [uist_pkg::ID_W-1:0]         new_reserved;
        logic [uist_pkg::IN_PAYLOAD_W-1:0] word;
        uist_pkg::t_mode                   mode;
        int                                phase_left;
        int                                burst_left;

        table_model = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. With reserved id zero: the reserved id itself is
        // refused, manual ids are stored, and the automatic counter skips
        // over ids already taken, restarting its scan after each hit.
        write_reserved('0);
        send_request(uist_pkg::MODE_MANUAL, '0, '0);
        send_request(uist_pkg::MODE_MANUAL, 32'd2, ID_MAX);
        send_request(uist_pkg::MODE_MANUAL, 32'd3, '0);
        send_request(uist_pkg::MODE_AUTO, ID_MAX, 32'h5a5a_a5a5);
        send_request(uist_pkg::MODE_AUTO, '0, 32'h0000_0001);
        send_request(uist_pkg::MODE_MANUAL, 32'd2, 32'h8000_0000);
        send_request(uist_pkg::MODE_MANUAL, ID_MAX, 32'h7fff_ffff);
        send_request(uist_pkg::MODE_MANUAL, 32'd6, 32'h1234_5678);
        send_request(uist_pkg::MODE_AUTO, 32'h8000_0000, ID_MAX);

        // The top id becomes reserved, which frees zero for use.
        write_reserved(ID_MAX);
        send_request(uist_pkg::MODE_MANUAL, ID_MAX, 32'hdead_0001);
        send_request(uist_pkg::MODE_MANUAL, '0, 32'hdead_0002);
        send_request(uist_pkg::MODE_AUTO, 32'h0000_ffff, 32'hdead_0003);

        // The automatic scan now runs straight into the reserved id and the
        // request is refused rather than stepping past it.
        write_reserved(32'd9);
        send_request(uist_pkg::MODE_MANUAL, 32'd8, 32'hbeef_0001);
        send_request(uist_pkg::MODE_AUTO, '0, 32'hbeef_0002);
        send_request(uist_pkg::MODE_MANUAL, 32'd9, 32'hbeef_0003);

        // Fill the table, then check that a full table still reports
        // duplicates and the reserved id as rejections before fullness.
        for (int i = 0; i < 6; i++) begin
            send_request(uist_pkg::MODE_MANUAL, 32'd100 + i, $urandom);
        end
        send_request(uist_pkg::MODE_MANUAL, 32'd200, $urandom);
        send_request(uist_pkg::MODE_MANUAL, 32'd100, $urandom);
        send_request(uist_pkg::MODE_MANUAL, 32'd9, $urandom);
        send_request(uist_pkg::MODE_AUTO, $urandom, $urandom);

        // Random part in phases. Each phase starts from an idle table with a
        // new reserved id: an extreme, a stored id, a random value, or one just
        // ahead of the automatic counter so that the scan can land on it.
        phase_left = 0;
        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 4))
                    0: begin
                        new_reserved = '0;
                    end
                    1: begin
                        new_reserved = ID_MAX;
                    end
                    2: begin
                        new_reserved = table_model.auto_id + $urandom_range(1, 6);
                    end
                    3: begin
                        new_reserved = table_model.entry_ids[
                            $urandom_range(0, table_model.entry_count - 1)];
                    end
                    default: begin
                        new_reserved = $urandom;
                    end
                endcase
                write_reserved(new_reserved);
                phase_left = $urandom_range(60, 140);
            end
            phase_left--;

            // Bursts of random length; most are preceded by a short gap.
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    idle_cycles($urandom_range(1, 12));
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;

            // Manual ids favor values that collide with something: stored
            // ids, the reserved id, ids near the counter and small numbers.
            case ($urandom_range(0, 9))
                0, 1: begin
                    want_id = $urandom;
                end
                2: begin
                    want_id = table_model.reserved_id;
                end
                3, 4: begin
                    want_id = table_model.entry_ids[
                        $urandom_range(0, table_model.entry_count - 1)];
                end
                5: begin
                    want_id = table_model.auto_id + $urandom_range(1, 4);
                end
                6: begin
                    want_id = ($urandom_range(0, 1) != 0) ? ID_MAX : '0;
                end
                default: begin
                    want_id = $urandom_range(0, 40);
                end
            endcase
            mode = ($urandom_range(0, 1) != 0) ? uist_pkg::MODE_MANUAL
                                               : uist_pkg::MODE_AUTO;
            word = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
            send_request(mode, want_id, word);
        end

        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (table_model.mismatches == 0 && table_model.pending_answers.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
